[rtl/core/gch_pkg.sv]
// ----------------------------------------------------------------------------
// gch_pkg
// Shared types and constants of the grouped count histogram: filter letters,
// bin geometry, register indexes and the bin edge bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gch_pkg;

  localparam int unsigned NUM_FILTERS = 5;
  localparam int unsigned NUM_RANGES  = 4;
  localparam int unsigned NUM_BINS    = NUM_FILTERS * NUM_RANGES;
  localparam int unsigned BIN_W       = 5;
  localparam int unsigned BIN_COUNT_W = 32;
  localparam int unsigned STAR_W      = 32;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned EDGE_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  // Filter letters in bin order: B, C, I, R, V
  localparam logic [CODE_W-1:0] FILTER_CODE [NUM_FILTERS] = '{
    8'd66, 8'd67, 8'd73, 8'd82, 8'd86
  };

  // Register reset values
  localparam logic signed [MAG_W-1:0] MAG_FLOOR_RST = -16'sd5000;
  localparam logic [EDGE_W-1:0]       EDGE_LOW_RST  = 16'd10;
  localparam logic [EDGE_W-1:0]       EDGE_MID_RST  = 16'd50;
  localparam logic [EDGE_W-1:0]       EDGE_HIGH_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAG_FLOOR = 2'd0,
    CFG_EDGE_LOW  = 2'd1,
    CFG_EDGE_MID  = 2'd2,
    CFG_EDGE_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    logic [EDGE_W-1:0] low;
    logic [EDGE_W-1:0] mid;
    logic [EDGE_W-1:0] high;
  } bin_edges_t;

  // One-hot filter match of an ASCII code; zero for letters not counted
  function automatic logic [NUM_FILTERS-1:0] filter_hit(input logic [CODE_W-1:0] code);
    logic [NUM_FILTERS-1:0] hit;
    hit = '0;
    for (int f = 0; f < NUM_FILTERS; f++) begin
      hit[f] = (code == FILTER_CODE[f]);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gch_binner.sv]
// ----------------------------------------------------------------------------
// gch_binner
// Bins the five per-star filter counts of the open run: picks a range for
// each nonzero count from the edges; returns the histogram, those bins bumped.
// ----------------------------------------------------------------------------
`default_nettype none

module gch_binner
  import gch_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned HIST_BITS  = 32
) (
  input  logic [NUM_FILTERS-1:0][COUNT_BITS-1:0] counts_i,
  input  bin_edges_t                             edges_i,
  input  logic [NUM_BINS-1:0][HIST_BITS-1:0]     hist_i,
  output logic [NUM_BINS-1:0][HIST_BITS-1:0]     hist_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > EDGE_W) ? COUNT_BITS : EDGE_W;

  logic [NUM_BINS-1:0] bump;

  // Range select per filter; edges tested in order low, mid, high
  always_comb begin
    logic [CMP_W-1:0] cnt;
    bump = '0;
    for (int f = 0; f < NUM_FILTERS; f++) begin
      cnt = CMP_W'(counts_i[f]);
      if (cnt != '0) begin
        if (cnt <= CMP_W'(edges_i.low)) begin
          bump[f*NUM_RANGES + 0] = 1'b1;
        end else if (cnt <= CMP_W'(edges_i.mid)) begin
          bump[f*NUM_RANGES + 1] = 1'b1;
        end else if (cnt <= CMP_W'(edges_i.high)) begin
          bump[f*NUM_RANGES + 2] = 1'b1;
        end else begin
          bump[f*NUM_RANGES + 3] = 1'b1;
        end
      end
    end
  end

  // Saturating increment of the selected bins
  always_comb begin
    for (int k = 0; k < NUM_BINS; k++) begin
      if (bump[k] && (hist_i[k] != {HIST_BITS{1'b1}})) begin
        hist_o[k] = hist_i[k] + HIST_BITS'(1);
      end else begin
        hist_o[k] = hist_i[k];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/grouped_count_histogram.sv]
// ----------------------------------------------------------------------------
// grouped_count_histogram
// Per-star filter count histogram over a stream of measurement records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries records and finish
//   requests. A record is absorbed in the cycle it is accepted, so records
//   flow at one per cycle, also while a histogram is being read out.
//   A finish request bins the open run and copies the twenty counters into an
//   output shift register in the same cycle, then clears the live state.
//   The output channel (out_valid_o / out_stall_i) shows the first bin in the
//   cycle after the finish is accepted and then one bin per cycle that the
//   receiver does not stall; the twentieth carries last_o. A stall holds the
//   current bin in place.
//   A second finish waits (in_stall_o high) until the readout of the previous
//   histogram has finished; records are never stalled.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   should only happen while the block is idle.
//   Reset clears counts, current star and histogram and loads the default
//   magnitude floor and bin edges.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_count_histogram
  import gch_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned HIST_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [STAR_W-1:0]             star_index_i,
  input  logic [CODE_W-1:0]             filter_code_i,
  input  logic signed [MAG_W-1:0]       magnitude_i,
  // histogram results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [BIN_W-1:0]              bin_index_o,
  output logic [BIN_COUNT_W-1:0]        bin_count_o,
  output logic                          last_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  // Configuration registers
  logic signed [MAG_W-1:0] mag_floor_q;
  bin_edges_t              edges_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_floor_q  <= MAG_FLOOR_RST;
      edges_q.low  <= EDGE_LOW_RST;
      edges_q.mid  <= EDGE_MID_RST;
      edges_q.high <= EDGE_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MAG_FLOOR: mag_floor_q  <= MAG_W'(cfg_data_i);
        CFG_EDGE_LOW:  edges_q.low  <= EDGE_W'(cfg_data_i);
        CFG_EDGE_MID:  edges_q.mid  <= EDGE_W'(cfg_data_i);
        CFG_EDGE_HIGH: edges_q.high <= EDGE_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Live state
  logic [NUM_FILTERS-1:0][COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [STAR_W-1:0]                      star_q, star_d;
  logic [NUM_BINS-1:0][HIST_BITS-1:0]     hist_q, hist_d, hist_binned;

  // Readout
  logic [HIST_BITS-1:0] snap_q [NUM_BINS];
  logic [HIST_BITS-1:0] snap_d [NUM_BINS];
  logic                 busy_q, busy_d;
  logic [BIN_W-1:0]     idx_q, idx_d;

  logic in_acc, out_acc, rec_acc, fin_acc, rec_ok, new_star;
  logic [NUM_FILTERS-1:0] hit;

  assign in_stall_o = busy_q && (op_e'(op_i) == OP_FINISH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign rec_acc    = in_acc && (op_e'(op_i) == OP_RECORD);
  assign fin_acc    = in_acc && (op_e'(op_i) == OP_FINISH);
  assign rec_ok     = rec_acc && (magnitude_i > mag_floor_q);
  assign new_star   = star_index_i != star_q;
  assign hit        = filter_hit(filter_code_i);

  gch_binner #(
    .COUNT_BITS(COUNT_BITS),
    .HIST_BITS (HIST_BITS)
  ) u_binner (
    .counts_i(cnt_q),
    .edges_i (edges_q),
    .hist_i  (hist_q),
    .hist_o  (hist_binned)
  );

  // Record and finish update of counts, star and histogram
  always_comb begin
    logic [COUNT_BITS-1:0] base;
    base   = '0;
    cnt_d  = cnt_q;
    star_d = star_q;
    hist_d = hist_q;
    if (fin_acc) begin
      cnt_d  = '0;
      star_d = '0;
      hist_d = '0;
    end else if (rec_ok) begin
      if (new_star) begin
        hist_d = hist_binned;
        star_d = star_index_i;
      end
      for (int f = 0; f < NUM_FILTERS; f++) begin
        base = new_star ? '0 : cnt_q[f];
        if (hit[f] && (base != {COUNT_BITS{1'b1}})) begin
          cnt_d[f] = base + COUNT_BITS'(1);
        end else begin
          cnt_d[f] = base;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      star_q <= '0;
      hist_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      star_q <= star_d;
      hist_q <= hist_d;
    end
  end

  // Readout control: load on finish, step on each taken result
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    for (int k = 0; k < NUM_BINS; k++) begin
      snap_d[k] = snap_q[k];
    end
    if (fin_acc) begin
      busy_d = 1'b1;
      idx_d  = '0;
      for (int k = 0; k < NUM_BINS; k++) begin
        snap_d[k] = hist_binned[k];
      end
    end else if (out_acc) begin
      if (idx_q == LAST_BIN) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + BIN_W'(1);
      for (int k = 0; k < NUM_BINS - 1; k++) begin
        snap_d[k] = snap_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Readout shift register, payload only
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_BINS; k++) begin
      snap_q[k] <= snap_d[k];
    end
  end

  assign out_valid_o = busy_q;
  assign bin_index_o = idx_q;
  assign bin_count_o = BIN_COUNT_W'(snap_q[0]);
  assign last_o      = (idx_q == LAST_BIN);

endmodule

`default_nettype wire

[rtl/core/gch_checker.sv]
// ----------------------------------------------------------------------------
// gch_checker
// Port-level checks of the grouped count histogram readout sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module gch_checker
  import gch_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   op_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [BIN_W-1:0]       bin_index_o,
  input logic [BIN_COUNT_W-1:0] bin_count_o,
  input logic                   last_o
);

  logic fin_acc, out_acc;
  assign fin_acc = in_valid_i && !in_stall_o && (op_e'(op_i) == OP_FINISH);
  assign out_acc = out_valid_o && !out_stall_i;

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_index_o)
      && $stable(bin_count_o))
    else $error("stalled result changed");

  // A finish request starts readout at bin zero
  a_finish_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_acc |=> out_valid_o && (bin_index_o == '0))
    else $error("finish did not start readout at bin zero");

  // Readout runs through consecutive bins without gaps
  a_bin_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o
      && (bin_index_o == $past(bin_index_o) + BIN_W'(1)))
    else $error("readout skipped or stopped early");

  // Last flag marks exactly the final bin
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (bin_index_o == LAST_BIN)))
    else $error("last flag on wrong bin");

endmodule

bind grouped_count_histogram gch_checker u_gch_checker (.*);

`default_nettype wire
